[rtl/heightmap_normal_map_top_assert.svh]
// Assertion macros used by the top-level RTL file.
`ifndef HEIGHTMAP_NORMAL_MAP_TOP_ASSERT_SVH
`define HEIGHTMAP_NORMAL_MAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define HMN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define HMN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HMN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HMN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/hmn_pkg.sv]
package hmn_pkg;

  localparam int SCALE_W = 8;
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd127;

  // Quotient digits searched per component.
  localparam int Q_W = 8;
  localparam logic [Q_W-1:0] Q_CAP = 8'd128;
  localparam logic [Q_W-1:0] Q_POS_MAX = 8'd127;

  localparam int POS_W = 6;
  localparam int HEIGHT_W = 16;

endpackage

[rtl/heightmap_normal_map_top.sv]
// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   height_i
// result    out        out_valid_o / out_stall_i normal_x/y/z, point_row/col, run_end
// config    in         cfg_we_i                  cfg_wdata_i (scale)
//
// One input word yields 0 to 3 normals; the shared shift-add multiplier sets most
// of the time that each normal takes.
// Each normal needs eight serial multiplies and three digit searches.
// rst_ni is asynchronous, active low; line memory contents are not cleared.
// A waiting result sits in the output register; the next input word is taken
// meanwhile, and the sequencer holds only when a second result is ready.
`include "heightmap_normal_map_top_assert.svh"

module heightmap_normal_map_top #(
  parameter int GRID        = 33,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hmn_pkg::HEIGHT_W-1:0]  height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    normal_x_o,
  output logic [7:0]                    normal_y_o,
  output logic [6:0]                    normal_z_o,
  output logic [hmn_pkg::POS_W-1:0]     point_row_o,
  output logic [hmn_pkg::POS_W-1:0]     point_col_o,
  output logic                          run_end_o,
  input  logic                          cfg_we_i,
  input  logic [hmn_pkg::SCALE_W-1:0]   cfg_wdata_i
);

  localparam int HB    = HEIGHT_BITS;
  localparam int CW    = $clog2(GRID);
  localparam int AW    = CW + 2;
  localparam int DEPTH = 4 << CW;
  localparam int SMW   = HB + hmn_pkg::SCALE_W;
  localparam int NW    = 2 * SMW;
  localparam int DW    = 2 * HB + 2;
  localparam int QW    = hmn_pkg::Q_W;
  localparam int PW    = hmn_pkg::POS_W;
  localparam logic [CW-1:0] LAST = CW'(GRID - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NEXT  = 4'd1;
  localparam logic [3:0] S_RADDR = 4'd2;
  localparam logic [3:0] S_RDATA = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_SQX   = 4'd5;
  localparam logic [3:0] S_SQY   = 4'd6;
  localparam logic [3:0] S_SM    = 4'd7;
  localparam logic [3:0] S_NUM   = 4'd8;
  localparam logic [3:0] S_SRCH  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // Three line banks rotate roles at each row end; bank 3 stays unused.
  logic [HB-1:0] mem [DEPTH];

  logic [3:0] state_q, state_d;
  logic [CW-1:0] row_q, col_q, it_r_q, it_c_q, pc_q, prow_q;
  logic [1:0] cur_b_q, prv_b_q, old_b_q, s_cur_q, s_prv_q, s_old_q;
  logic [1:0] ub_q, mb_q, db_q, rd_k_q, comp_q;
  logic [2:0] eb_q;
  logic last_q;
  logic [hmn_pkg::SCALE_W-1:0] scale_q;
  logic [AW-1:0] rd_addr;
  logic [HB-1:0] rd_data_q, op_l_q, op_r_q, op_u_q, op_d_q;
  logic [HB:0] x_q, y_q, x_neg, y_neg;
  logic [HB-1:0] ax, ay;
  logic [DW-1:0] sqx_q, d_q;
  logic [SMW-1:0] sm_q, mul_a, mul_b, m_sel;
  logic [NW-1:0] num_q, mul_p;
  logic [QW-1:0] qx_q, qy_q, qz_q, srch_q;
  logic mul_go_q, mul_go_d, srch_go_q, srch_go_d, mul_done, srch_done;
  logic in_acc, out_free;
  logic [HB+15:0] h_ext;
  logic [CW+PW-1:0] prow_ext, pc_ext;

  logic out_valid_q, run_end_q;
  logic [7:0] nx_q, ny_q;
  logic [6:0] nz_q;
  logic [PW-1:0] orow_q, ocol_q;
  logic [QW-1:0] qxc, qyc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign h_ext      = {{HB{1'b0}}, height_i};

  // Operand address: left, right, up, down of the point column.
  always_comb begin
    case (rd_k_q)
      2'd0:    rd_addr = {mb_q, (pc_q == '0) ? pc_q : pc_q - CW'(1)};
      2'd1:    rd_addr = {mb_q, (pc_q == LAST) ? pc_q : pc_q + CW'(1)};
      2'd2:    rd_addr = {ub_q, pc_q};
      default: rd_addr = {db_q, pc_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[{cur_b_q, col_q}] <= h_ext[HB-1:0];
    end
    rd_data_q <= mem[rd_addr];
  end

  assign x_neg = '0 - x_q;
  assign y_neg = '0 - y_q;
  assign ax    = x_q[HB] ? x_neg[HB-1:0] : x_q[HB-1:0];
  assign ay    = y_q[HB] ? y_neg[HB-1:0] : y_q[HB-1:0];

  always_comb begin
    case (comp_q)
      2'd0:    m_sel = SMW'(ax);
      2'd1:    m_sel = SMW'(ay);
      default: m_sel = SMW'(2);
    endcase
  end

  always_comb begin
    case (state_q)
      S_SQX:   begin mul_a = SMW'(ax); mul_b = SMW'(ax); end
      S_SQY:   begin mul_a = SMW'(ay); mul_b = SMW'(ay); end
      S_SM:    begin mul_a = m_sel;    mul_b = SMW'(scale_q); end
      default: begin mul_a = sm_q;     mul_b = sm_q; end
    endcase
  end

  hmn_smul #(.W(SMW)) u_smul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  hmn_qsrch #(.DW(DW), .NW(NW)) u_qsrch (
    .clk_i, .rst_ni, .start_i(srch_go_q), .d_i(d_q), .num_i(num_q),
    .done_o(srch_done), .q_o(srch_q)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    mul_go_d  = 1'b0;
    srch_go_d = 1'b0;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_NEXT;
      S_NEXT:  state_d = (eb_q == 3'b000) ? S_IDLE : S_RADDR;
      S_RADDR: state_d = S_RDATA;
      S_RDATA: state_d = (rd_k_q == 2'd3) ? S_DIFF : S_RADDR;
      S_DIFF:  begin state_d = S_SQX; mul_go_d = 1'b1; end
      S_SQX:   if (mul_done) begin state_d = S_SQY; mul_go_d = 1'b1; end
      S_SQY:   if (mul_done) begin state_d = S_SM; mul_go_d = 1'b1; end
      S_SM:    if (mul_done) begin state_d = S_NUM; mul_go_d = 1'b1; end
      S_NUM:   if (mul_done) begin state_d = S_SRCH; srch_go_d = 1'b1; end
      S_SRCH: begin
        if (srch_done) begin
          if (comp_q == 2'd2) begin
            state_d = S_OUT;
          end else begin
            state_d  = S_SM;
            mul_go_d = 1'b1;
          end
        end
      end
      S_OUT:   if (out_free) state_d = S_NEXT;
      default: state_d = S_IDLE;
    endcase
  end

  // Cap quotients, then attach the component sign.
  assign qxc = (qx_q > hmn_pkg::Q_CAP) ? hmn_pkg::Q_CAP : qx_q;
  assign qyc = (qy_q > hmn_pkg::Q_CAP) ? hmn_pkg::Q_CAP : qy_q;
  assign prow_ext = {{PW{1'b0}}, prow_q};
  assign pc_ext   = {{PW{1'b0}}, pc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q <= '0; col_q <= '0;
      cur_b_q <= 2'd0; prv_b_q <= 2'd1; old_b_q <= 2'd2;
      s_cur_q <= 2'd0; s_prv_q <= 2'd1; s_old_q <= 2'd2;
      it_r_q <= '0; it_c_q <= '0; pc_q <= '0; prow_q <= '0;
      ub_q <= '0; mb_q <= '0; db_q <= '0; rd_k_q <= '0; comp_q <= '0;
      eb_q <= '0; last_q <= 1'b0;
      scale_q <= hmn_pkg::SCALE_RST;
      op_l_q <= '0; op_r_q <= '0; op_u_q <= '0; op_d_q <= '0;
      x_q <= '0; y_q <= '0; sqx_q <= '0; d_q <= '0; sm_q <= '0; num_q <= '0;
      qx_q <= '0; qy_q <= '0; qz_q <= '0;
      mul_go_q <= 1'b0; srch_go_q <= 1'b0;
      out_valid_q <= 1'b0; run_end_q <= 1'b0;
      nx_q <= '0; ny_q <= '0; nz_q <= '0; orow_q <= '0; ocol_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_go_q  <= mul_go_d;
      srch_go_q <= srch_go_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      // Drop the taken word unless a new one replaces it this cycle.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            // Snapshot roles before the row end rotates them.
            it_r_q  <= row_q;
            it_c_q  <= col_q;
            s_cur_q <= cur_b_q;
            s_prv_q <= prv_b_q;
            s_old_q <= old_b_q;
            eb_q <= {(row_q == LAST) && (col_q == LAST),
                     (row_q == LAST) && (col_q != '0),
                     (row_q != '0)};
            if (col_q == LAST) begin
              col_q   <= '0;
              old_b_q <= prv_b_q;
              prv_b_q <= cur_b_q;
              cur_b_q <= old_b_q;
              row_q   <= (row_q == LAST) ? '0 : row_q + CW'(1);
            end else begin
              col_q <= col_q + CW'(1);
            end
          end
        end
        S_NEXT: begin
          rd_k_q <= 2'd0;
          comp_q <= 2'd0;
          if (eb_q[0]) begin
            // Point one row above the incoming word.
            pc_q   <= it_c_q;
            prow_q <= it_r_q - CW'(1);
            ub_q   <= (it_r_q == CW'(1)) ? s_prv_q : s_old_q;
            mb_q   <= s_prv_q;
            db_q   <= s_cur_q;
            eb_q[0] <= 1'b0;
            last_q <= !(eb_q[1] || eb_q[2]);
          end else if (eb_q[1]) begin
            // Last row, point left of the incoming word.
            pc_q   <= it_c_q - CW'(1);
            prow_q <= it_r_q;
            ub_q   <= s_prv_q;
            mb_q   <= s_cur_q;
            db_q   <= s_cur_q;
            eb_q[1] <= 1'b0;
            last_q <= !eb_q[2];
          end else begin
            // Bottom right corner.
            pc_q   <= it_c_q;
            prow_q <= it_r_q;
            ub_q   <= s_prv_q;
            mb_q   <= s_cur_q;
            db_q   <= s_cur_q;
            eb_q[2] <= 1'b0;
            last_q <= 1'b1;
          end
        end
        S_RDATA: begin
          case (rd_k_q)
            2'd0:    op_l_q <= rd_data_q;
            2'd1:    op_r_q <= rd_data_q;
            2'd2:    op_u_q <= rd_data_q;
            default: op_d_q <= rd_data_q;
          endcase
          rd_k_q <= rd_k_q + 2'd1;
        end
        S_DIFF: begin
          x_q <= {op_r_q[HB-1], op_r_q} - {op_l_q[HB-1], op_l_q};
          y_q <= {op_u_q[HB-1], op_u_q} - {op_d_q[HB-1], op_d_q};
        end
        S_SQX: if (mul_done) sqx_q <= mul_p[DW-1:0];
        S_SQY: if (mul_done) d_q <= sqx_q + mul_p[DW-1:0] + DW'(4);
        S_SM:  if (mul_done) sm_q <= mul_p[SMW-1:0];
        S_NUM: if (mul_done) num_q <= mul_p;
        S_SRCH: begin
          if (srch_done) begin
            case (comp_q)
              2'd0:    qx_q <= srch_q;
              2'd1:    qy_q <= srch_q;
              default: qz_q <= srch_q;
            endcase
            comp_q <= comp_q + 2'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            nx_q <= x_q[HB] ? 8'd0 - qxc
                            : ((qxc > hmn_pkg::Q_POS_MAX) ? hmn_pkg::Q_POS_MAX : qxc);
            ny_q <= y_q[HB] ? 8'd0 - qyc
                            : ((qyc > hmn_pkg::Q_POS_MAX) ? hmn_pkg::Q_POS_MAX : qyc);
            nz_q <= (qz_q > hmn_pkg::Q_POS_MAX) ? hmn_pkg::Q_POS_MAX[6:0] : qz_q[6:0];
            orow_q    <= prow_ext[PW-1:0];
            ocol_q    <= pc_ext[PW-1:0];
            run_end_q <= last_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign point_row_o = orow_q;
  assign point_col_o = ocol_q;
  assign run_end_o   = run_end_q;

  `HMN_ASSERT_NXT(a_accept_next, clk_i, rst_ni, in_acc, state_q == S_NEXT)
  `HMN_ASSERT_IMP(a_corner_last_row, clk_i, rst_ni, eb_q[2], it_r_q == LAST)
  `HMN_ASSERT_IMP(a_pos_in_tile, clk_i, rst_ni, 1'b1, (row_q <= LAST) && (col_q <= LAST))

endmodule

[rtl/hmn_smul.sv]
module hmn_smul #(
  parameter int W = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] p_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [2*W-1:0] acc_q;
  logic [2*W-1:0] a_q;
  logic [W-1:0]   b_q;
  logic [CNT_W-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;

  // Shift-add: one multiplier bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q  <= '0;
        a_q    <= {{W{1'b0}}, a_i};
        b_q    <= b_i;
        cnt_q  <= CNT_W'(W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q   <= a_q << 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[rtl/hmn_qsrch.sv]
module hmn_qsrch #(
  parameter int DW = 34,
  parameter int NW = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DW-1:0]           d_i,
  input  logic [NW-1:0]           num_i,
  output logic                    done_o,
  output logic [hmn_pkg::Q_W-1:0] q_o
);

  localparam int TW = ((DW + 18) > (NW + 1)) ? (DW + 18) : (NW + 1);

  // Track P = q*q*d and Q = q*d so a trial digit costs only shifts and adds.
  logic [TW-1:0] d_q, num_q, p_q, qd_q, qt_q, t_q, trial;
  logic [hmn_pkg::Q_W-1:0] q_q;
  logic [2:0] b_q;
  logic ph_q, busy_q, done_q;

  assign trial = t_q + (qd_q << ({1'b0, b_q} + 4'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0; num_q <= '0; p_q <= '0; qd_q <= '0; qt_q <= '0; t_q <= '0;
      q_q <= '0; b_q <= '0; ph_q <= 1'b0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        d_q    <= TW'(d_i);
        num_q  <= TW'(num_i);
        p_q    <= '0;
        qd_q   <= '0;
        q_q    <= '0;
        b_q    <= 3'd7;
        ph_q   <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!ph_q) begin
          t_q  <= p_q + (d_q << {b_q, 1'b0});
          qt_q <= qd_q + (d_q << b_q);
          ph_q <= 1'b1;
        end else begin
          if (trial <= num_q) begin
            p_q      <= trial;
            qd_q     <= qt_q;
            q_q[b_q] <= 1'b1;
          end
          ph_q <= 1'b0;
          if (b_q == 3'd0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            b_q <= b_q - 3'd1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int TILE = 33;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 900;  // covers the longest word, which yields three normals
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [7:0]                nx;
    logic [7:0]                ny;
    logic [6:0]                nz;
    logic [hmn_pkg::POS_W-1:0] row;
    logic [hmn_pkg::POS_W-1:0] col;
    logic                      last;
  } normal_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [hmn_pkg::HEIGHT_W-1:0]     height_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [7:0]                       normal_x_o;
  logic [7:0]                       normal_y_o;
  logic [6:0]                       normal_z_o;
  logic [hmn_pkg::POS_W-1:0]        point_row_o;
  logic [hmn_pkg::POS_W-1:0]        point_col_o;
  logic                             run_end_o;
  logic                             cfg_we_i = 1'b0;
  logic [hmn_pkg::SCALE_W-1:0]      cfg_wdata_i = '0;

  heightmap_normal_map_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .height_i,
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o,
    .point_row_o, .point_col_o, .run_end_o, .cfg_we_i, .cfg_wdata_i
  );

  always #1 clk_i = ~clk_i;

  // Stimulus and scoreboard state.
  logic [hmn_pkg::HEIGHT_W-1:0] height_q[$];
  normal_t             normals_due[$];
  int                  mismatches = 0;
  int                  normals_seen = 0;
  int                  words_taken = 0;
  int                  cycles = 0;
  logic                word_fire = 1'b0;
  logic                calm = 1'b0;      // no random idling on either side
  logic                hold_go = 1'b0;
  logic                hold_done = 1'b0;
  int                  hold_left = 0;

  // Predictor copy of the block: three line buffers, position, scale.
  int                  up_line[TILE];
  int                  mid_line[TILE];
  int                  cur_line[TILE];
  int                  row_at = 0;
  int                  col_at = 0;
  int unsigned         scale_now = hmn_pkg::SCALE_RST;

  // Largest q <= 128 with q*q*den <= (scale*mag)^2.
  function automatic int unsigned trunc_quot(longint unsigned mag, longint unsigned den);
    longint unsigned lim;
    int unsigned     q;
    lim = (longint'(scale_now) * scale_now * mag * mag) / den;
    q = 0;
    while (q < 128 && longint'(q + 1) * (q + 1) <= lim) q++;
    return q;
  endfunction

  function automatic logic [7:0] sat_signed(int comp, int unsigned q);
    if (comp < 0) return 8'(-int'(q));
    return 8'((q > 127) ? 127 : q);
  endfunction

  function automatic normal_t shade_point(int up_h, int left_h, int right_h, int down_h,
                                          int r, int c);
    normal_t         n;
    int              gx, gy;
    longint unsigned ax, ay, den;
    int unsigned     qz;
    gx = right_h - left_h;
    gy = up_h - down_h;
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    den = ax * ax + ay * ay + 4;
    qz = trunc_quot(2, den);
    n.nx = sat_signed(gx, trunc_quot(ax, den));
    n.ny = sat_signed(gy, trunc_quot(ay, den));
    n.nz = 7'((qz > 127) ? 127 : qz);
    n.row = hmn_pkg::POS_W'(r);
    n.col = hmn_pkg::POS_W'(c);
    n.last = 1'b0;
    return n;
  endfunction

  // Point (r,c) from the rows above, at and below it, edges clamped.
  function automatic normal_t point_from(const ref int a[TILE], const ref int m[TILE],
                                         const ref int b[TILE], input int r, input int c);
    int lc, rc;
    lc = (c == 0) ? c : c - 1;
    rc = (c + 1 >= TILE) ? c : c + 1;
    return shade_point(a[c], m[lc], m[rc], b[c], r, c);
  endfunction

  task automatic predict_word(logic [hmn_pkg::HEIGHT_W-1:0] h);
    normal_t got[$];
    normal_t n;
    cur_line[col_at] = int'($signed(h));
    if (row_at >= 1) begin
      if (row_at == 1) n = point_from(mid_line, mid_line, cur_line, row_at - 1, col_at);
      else n = point_from(up_line, mid_line, cur_line, row_at - 1, col_at);
      got.push_back(n);
    end
    if (row_at == TILE - 1) begin
      // Bottom row: emit the left neighbor, and the corner at the row end.
      if (col_at >= 1)
        got.push_back(point_from(mid_line, cur_line, cur_line, row_at, col_at - 1));
      if (col_at == TILE - 1)
        got.push_back(point_from(mid_line, cur_line, cur_line, row_at, col_at));
    end
    if (got.size() > 0) got[$].last = 1'b1;
    foreach (got[i]) normals_due.push_back(got[i]);
    col_at++;
    if (col_at >= TILE) begin
      col_at = 0;
      up_line = mid_line;
      mid_line = cur_line;
      row_at = (row_at + 1 >= TILE) ? 0 : row_at + 1;
    end
  endtask

  // Sample at the rising edge: predict accepted words, check results, track scale.
  always @(posedge clk_i) begin
    normal_t want;
    normal_t seen;
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d normals still due",
               cycles, normals_due.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) scale_now = cfg_wdata_i;
      word_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_word(height_i);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{normal_x_o, normal_y_o, normal_z_o, point_row_o, point_col_o, run_end_o};
        normals_seen++;
        if (normals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected normal %p", seen);
        end else begin
          want = normals_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch at (%0d,%0d): expected x=%0d y=%0d z=%0d end=%0b, ",
                        "got (%0d,%0d) x=%0d y=%0d z=%0d end=%0b"},
                       want.row, want.col, $signed(want.nx), $signed(want.ny), want.nz,
                       want.last, seen.row, seen.col, $signed(seen.nx), $signed(seen.ny),
                       seen.nz, seen.last);
          end
        end
      end
    end
  end

  // Sender: advance only after a word was taken or while nothing is offered.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_fire)) begin
      if (height_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        in_valid_i <= 1'b1;
        height_i <= height_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 7);
    end
  end

  // Mix random walks (small gradients) with full-range and near-zero heights.
  int walk_h = 0;
  function automatic logic [hmn_pkg::HEIGHT_W-1:0] pick_height();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) walk_h = walk_h + $urandom_range(64) - 32;
    else if (sel < 80) walk_h = int'($signed(hmn_pkg::HEIGHT_W'($urandom)));
    else walk_h = $urandom_range(6) - 3;
    return hmn_pkg::HEIGHT_W'(walk_h);
  endfunction

  task automatic queue_random(int count);
    repeat (count) height_q.push_back(pick_height());
  endtask

  // Wait until the sender has run dry and the block is empty, then write the scale.
  task automatic settle_and_scale(logic [hmn_pkg::SCALE_W-1:0] s);
    wait (height_q.size() == 0 && !in_valid_i);
    wait (normals_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    foreach (cur_line[i]) begin
      up_line[i] = 0;
      mid_line[i] = 0;
      cur_line[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed row-0 words: extremes and sign edges, then random; reset scale.
    height_q = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff,
                 16'h8000, 16'h8000, 16'h0000, 16'h5555, 16'haaaa, 16'h7fff, 16'h8000,
                 16'h0002, 16'hfffe, 16'h0000, 16'h0000, 16'h7fff, 16'h8000};
    queue_random(100);
    settle_and_scale(8'd255);
    queue_random(80);
    hold_go <= 1'b1;
    queue_random(80);
    settle_and_scale(8'd1);
    calm <= 1'b1;
    queue_random(90);
    settle_and_scale(8'd0);
    calm <= 1'b0;
    queue_random(50);
    settle_and_scale(hmn_pkg::SCALE_W'($urandom_range(254, 2)));
    queue_random(25);
    settle_and_scale(hmn_pkg::SCALE_W'($urandom_range(254, 2)));
    queue_random(25);

    wait (height_q.size() == 0 && !in_valid_i);
    wait (normals_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d height words and %0d normals over the upper rows of a tile,",
             words_taken, normals_seen);
    $display("scales 127, 255, 1, 0 and two random, with a long output hold-off.");
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[heightmap_normal_map_top.f]
+incdir+rtl
rtl/hmn_pkg.sv
rtl/hmn_smul.sv
rtl/hmn_qsrch.sv
rtl/heightmap_normal_map_top.sv
dv/tb.sv
